FILE: rtl/core/ill_pkg.sv
// shared types and constants for the indexed list core
// no dependencies; imported by the interfaces, the cell and the top level
`timescale 1ns / 1ps

package ill_pkg;

  localparam int CAPACITY_DEFAULT = 64;
  localparam int KIND_W           = 2;
  localparam int POS_W            = 7;
  localparam int VALUE_W          = 32;
  localparam int STATUS_W         = 2;
  localparam int COUNT_OUT_W      = 7;

  typedef enum logic [KIND_W-1:0] {
    REQ_READ   = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_APPEND = 2'd3
  } req_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic ins;
    logic del;
  } cell_cmd_t;

endpackage

FILE: rtl/core/ill_if.sv
// request and response word channels of the indexed list core
// depends on ill_pkg for field widths
`timescale 1ns / 1ps

interface ill_req_if;
  logic                                valid;
  logic                                ready;
  logic        [ill_pkg::KIND_W-1:0]   req_type;
  logic        [ill_pkg::POS_W-1:0]    position;
  logic signed [ill_pkg::VALUE_W-1:0]  item_value;

  modport source (output valid, req_type, position, item_value, input ready);
  modport sink   (input valid, req_type, position, item_value, output ready);
endinterface

interface ill_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ill_pkg::VALUE_W-1:0]    read_value;
  logic        [ill_pkg::STATUS_W-1:0]   status;
  logic        [ill_pkg::COUNT_OUT_W-1:0] item_count;

  modport source (output valid, read_value, status, item_count, input ready);
  modport sink   (input valid, read_value, status, item_count, output ready);
endinterface

FILE: rtl/core/ill_cell.sv
// one list slot: holds a value and shifts it to or from its neighbors
// depends on ill_pkg for the cell command struct
`timescale 1ns / 1ps

module ill_cell #(
  parameter int INDEX = 0,
  parameter int PW    = 8
) (
  input  logic                              clk,
  input  ill_pkg::cell_cmd_t                cmd,
  input  logic [PW-1:0]                     tgt,
  input  logic [PW-1:0]                     rd_pos,
  input  logic signed [ill_pkg::VALUE_W-1:0] item_value,
  input  logic signed [ill_pkg::VALUE_W-1:0] left_value,
  input  logic signed [ill_pkg::VALUE_W-1:0] right_value,
  output logic signed [ill_pkg::VALUE_W-1:0] value,
  output logic signed [ill_pkg::VALUE_W-1:0] rd_value
);
  import ill_pkg::*;

  localparam logic [PW-1:0] MY_IDX = PW'(INDEX);

  logic at_tgt;
  logic past_tgt;

  assign at_tgt   = (MY_IDX == tgt);
  assign past_tgt = (MY_IDX > tgt);

  always_ff @(posedge clk) begin
    if (cmd.ins && at_tgt) begin
      value <= item_value;
    end else if (cmd.ins && past_tgt) begin
      value <= left_value;
    end else if (cmd.del && (at_tgt || past_tgt)) begin
      value <= right_value;
    end
  end

  assign rd_value = (MY_IDX == rd_pos) ? value : '0;

endmodule

FILE: rtl/core/indexed_list_insert_delete_core.sv
// indexed list core: a row of CAPACITY slot cells that shift as a whole
// result word registered, valid in the cycle after the request is taken; insert and
// delete move every slot in one step; one request per cycle unless rsp stalls
// reset: clears the count and the result valid; slot contents stay undefined
// depends on ill_pkg, ill_if and ill_cell
`timescale 1ns / 1ps

module indexed_list_insert_delete_core #(
  parameter int CAPACITY = ill_pkg::CAPACITY_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  ill_req_if.sink  req,
  ill_rsp_if.source rsp
);
  import ill_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [PW-1:0] cnt_ext;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_next_ext;
  logic [PW-1:0] tgt;
  logic          accept;
  logic          is_full;
  cell_cmd_t     cmd;
  cell_cmd_t     cmd_raw;
  status_t       st_next;
  logic signed [VALUE_W-1:0] rd_next;
  logic signed [VALUE_W-1:0] rd_any;

  logic signed [VALUE_W-1:0] slot_value [CAPACITY];
  logic signed [VALUE_W-1:0] slot_rd    [CAPACITY];

  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value;
  status_t                   out_status;
  logic [COUNT_OUT_W-1:0]    out_count;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign cnt_ext   = PW'(count);
  assign pos_ext   = PW'(req.position);
  assign is_full   = (count == CAP_CNT);

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | slot_rd[i];
    end
  end

  always_comb begin
    cmd_raw    = '0;
    tgt        = pos_ext;
    st_next    = ST_DONE;
    rd_next    = '0;
    count_next = count;
    unique case (req_kind_t'(req.req_type))
      REQ_READ: begin
        if (pos_ext < cnt_ext) begin
          rd_next = rd_any;
        end else begin
          rd_next = -32'sd1;
          st_next = ST_RANGE;
        end
      end
      REQ_INSERT: begin
        if (pos_ext > cnt_ext) begin
          st_next = ST_RANGE;
        end else if (is_full) begin
          st_next = ST_FULL;
        end else begin
          cmd_raw.ins = 1'b1;
          count_next  = count + 1'b1;
        end
      end
      REQ_DELETE: begin
        if (pos_ext >= cnt_ext) begin
          st_next = ST_RANGE;
        end else begin
          cmd_raw.del = 1'b1;
          count_next  = count - 1'b1;
        end
      end
      REQ_APPEND: begin
        tgt = cnt_ext;
        if (is_full) begin
          st_next = ST_FULL;
        end else begin
          cmd_raw.ins = 1'b1;
          count_next  = count + 1'b1;
        end
      end
      default: begin
        st_next = ST_DONE;
      end
    endcase
  end

  assign cmd.ins      = cmd_raw.ins && accept;
  assign cmd.del      = cmd_raw.del && accept;
  assign cnt_next_ext = PW'(count_next);

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ill_cell #(
      .INDEX (g),
      .PW    (PW)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .tgt         (tgt),
      .rd_pos      (pos_ext),
      .item_value  (req.item_value),
      .left_value  ((g == 0) ? req.item_value : slot_value[(g == 0) ? 0 : g - 1]),
      .right_value ((g == CAPACITY - 1) ? slot_value[g]
                                        : slot_value[(g == CAPACITY - 1) ? g : g + 1]),
      .value       (slot_value[g]),
      .rd_value    (slot_rd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_value  <= rd_next;
      out_status <= st_next;
      out_count  <= cnt_next_ext[COUNT_OUT_W-1:0];
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_value;
  assign rsp.status     = out_status;
  assign rsp.item_count = out_count;

endmodule

FILE: bench/tb_indexed_list_insert_delete_core.sv
// testbench for indexed_list_insert_delete_core: directed and random requests
// checked word by word against a built-in list predictor
// depends on ill_pkg, ill_if and the core
`timescale 1ns / 1ps

module tb_indexed_list_insert_delete_core;
  import ill_pkg::*;

  localparam int LIST_DEPTH  = CAPACITY_DEFAULT;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_WORDS = 400;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    status_t                   status;
    logic [COUNT_OUT_W-1:0]    item_count;
  } list_result_t;

  logic clk;
  logic rst;

  ill_req_if req ();
  ill_rsp_if rsp ();

  indexed_list_insert_delete_core DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  logic signed [VALUE_W-1:0] list_slots [LIST_DEPTH];
  int                        list_len;
  list_result_t              expected_results [$];
  int                        error_count;
  int                        stall_cycles;
  bit                        steady_run;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic list_result_t predict_request(input req_kind_t kind,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic signed [VALUE_W-1:0] val);
    list_result_t r;
    int p;
    r.read_value = '0;
    r.status     = ST_DONE;
    p            = int'(pos);
    case (kind)
      REQ_READ: begin
        if (p < list_len) begin
          r.read_value = list_slots[p];
        end else begin
          r.read_value = -32'sd1;
          r.status     = ST_RANGE;
        end
      end
      REQ_INSERT: begin
        if (p > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = list_len; i > p; i--) list_slots[i] = list_slots[i-1];
          list_slots[p] = val;
          list_len++;
        end
      end
      REQ_DELETE: begin
        if (p >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = p; i + 1 < list_len; i++) list_slots[i] = list_slots[i+1];
          list_len--;
        end
      end
      default: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          list_slots[list_len] = val;
          list_len++;
        end
      end
    endcase
    r.item_count = list_len[COUNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic send_request(input req_kind_t kind, input logic [POS_W-1:0] pos,
                              input logic signed [VALUE_W-1:0] val);
    while (!steady_run && $urandom_range(99) < 25) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.req_type   <= kind;
    req.position   <= pos;
    req.item_value <= val;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    expected_results.push_back(predict_request(kind, pos, val));
  endtask

  // response side: random backpressure and checking
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result word: read_value %0d status %0d item_count %0d",
                 rsp.read_value, rsp.status, rsp.item_count);
          error_count++;
        end else begin
          list_result_t e;
          e = expected_results.pop_front();
          if (rsp.read_value !== e.read_value) begin
            $error("read_value: expected %0d, got %0d", e.read_value, rsp.read_value);
            error_count++;
          end
          if (rsp.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, rsp.status);
            error_count++;
          end
          if (rsp.item_count !== e.item_count) begin
            $error("item_count: expected %0d, got %0d", e.item_count, rsp.item_count);
            error_count++;
          end
        end
      end
      rsp.ready <= steady_run || ($urandom_range(99) >= 25);
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic test_empty_list();
    send_request(REQ_READ, 7'd0, 32'sd5);
    send_request(REQ_DELETE, 7'd0, 32'sd0);
    send_request(REQ_INSERT, 7'd1, 32'sd9);
    send_request(REQ_READ, 7'd127, 32'sd0);
    send_request(REQ_DELETE, 7'd127, 32'sd0);
  endtask

  task automatic test_insert_positions();
    send_request(REQ_INSERT, 7'd0, 32'sd100);
    send_request(REQ_APPEND, 7'd127, 32'sd200);
    // head insert on a longer list must land before the old head
    send_request(REQ_INSERT, 7'd0, 32'sd300);
    send_request(REQ_INSERT, 7'd3, 32'sd400);
    send_request(REQ_INSERT, 7'd2, 32'sd500);
    send_request(REQ_INSERT, 7'd127, 32'sd600);
    for (int i = 0; i < 6; i++) send_request(REQ_READ, i[POS_W-1:0], 32'sd0);
  endtask

  task automatic test_values_and_deletes();
    send_request(REQ_APPEND, 7'd0, 32'sh8000_0000);
    send_request(REQ_APPEND, 7'd0, 32'sh7fff_ffff);
    send_request(REQ_APPEND, 7'd0, -32'sd1);
    send_request(REQ_READ, 7'd5, 32'sd0);
    send_request(REQ_READ, 7'd6, 32'sd0);
    send_request(REQ_DELETE, 7'd7, 32'sd0);
    send_request(REQ_DELETE, 7'd0, 32'sd0);
    send_request(REQ_DELETE, 7'd2, 32'sd0);
    send_request(REQ_READ, 7'd2, 32'sd0);
    send_request(REQ_READ, 7'd5, 32'sd0);
  endtask

  // alternates fill and drain phases so the full and empty edges are both hit
  task automatic test_random_mix();
    bit growing;
    int edge_hits;
    int roll;
    req_kind_t kind;
    logic [POS_W-1:0] pos;
    logic signed [VALUE_W-1:0] val;
    growing   = 1'b1;
    edge_hits = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      steady_run = (n >= 150 && n < 230);
      roll = $urandom_range(99);
      if (growing) begin
        if (roll < 40) kind = REQ_APPEND;
        else if (roll < 80) kind = REQ_INSERT;
        else if (roll < 90) kind = REQ_DELETE;
        else kind = REQ_READ;
      end else begin
        if (roll < 65) kind = REQ_DELETE;
        else if (roll < 75) kind = REQ_INSERT;
        else if (roll < 80) kind = REQ_APPEND;
        else kind = REQ_READ;
      end
      if ($urandom_range(99) < 85) pos = POS_W'($urandom_range(0, list_len));
      else pos = POS_W'($urandom_range(0, 127));
      roll = $urandom_range(99);
      if (roll < 5) val = 32'sh8000_0000;
      else if (roll < 10) val = 32'sh7fff_ffff;
      else val = $urandom;
      if (growing && list_len == LIST_DEPTH) edge_hits++;
      if (!growing && list_len == 0) edge_hits++;
      if (edge_hits >= 4) begin
        growing   = !growing;
        edge_hits = 0;
      end
      send_request(kind, pos, val);
    end
    steady_run = 1'b0;
    req.valid <= 1'b0;
  endtask

  initial begin
    rst            <= 1'b1;
    req.valid      <= 1'b0;
    req.req_type   <= REQ_READ;
    req.position   <= '0;
    req.item_value <= '0;
    list_len       = 0;
    steady_run     = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_list();
    test_insert_positions();
    test_values_and_deletes();
    test_random_mix();

    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
